### rtl/core/mtp_pkg.sv
// shared types and constants for the mac address text parser
package mtp_pkg;

   localparam int ADDR_OCTETS = 6;
   localparam int ADDR_W      = 8 * ADDR_OCTETS;
   localparam int CNT_W       = $clog2(ADDR_OCTETS + 1);
   localparam int OUT_ADDR_W  = 48;
   localparam int GROUP_W     = 16;

   localparam logic [7:0] CH_TERM   = 8'h00;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_HYPHEN = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_F   = 8'h66;
   localparam logic [7:0] CH_UC_A   = 8'h41;
   localparam logic [7:0] CH_UC_F   = 8'h46;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_CHAR  = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_TOO_SHORT = 3'd3,
      ST_TOO_LONG  = 3'd4
   } status_type;

   typedef struct packed {
      logic       is_digit;
      logic [3:0] digit;
      logic       is_dot;
      logic       is_sep;
      logic       is_term;
      logic       is_bad;
   } char_class_type;

   typedef struct packed {
      logic [OUT_ADDR_W-1:0] address;
      status_type            status;
   } result_type;

endpackage

### rtl/core/mtp_char_decode.sv
// character classifier: hex digit value, separators, terminator
module mtp_char_decode import mtp_pkg::*; (
   input  logic [7:0]     ch,
   output char_class_type cls
);

   logic [7:0] dec_off;

   always_comb begin
      cls      = '0;
      dec_off  = '0;
      if (ch >= CH_0 && ch <= CH_9) begin
         dec_off      = ch - CH_0;
         cls.is_digit = 1'b1;
         cls.digit    = dec_off[3:0];
      end else if (ch >= CH_LC_A && ch <= CH_LC_F) begin
         dec_off      = ch - CH_LC_A + 8'd10;
         cls.is_digit = 1'b1;
         cls.digit    = dec_off[3:0];
      end else if (ch >= CH_UC_A && ch <= CH_UC_F) begin
         dec_off      = ch - CH_UC_A + 8'd10;
         cls.is_digit = 1'b1;
         cls.digit    = dec_off[3:0];
      end else if (ch == CH_DOT) begin
         cls.is_dot = 1'b1;
      end else if (ch == CH_COLON || ch == CH_HYPHEN) begin
         cls.is_sep = 1'b1;
      end else if (ch == CH_TERM) begin
         cls.is_term = 1'b1;
      end else begin
         cls.is_bad = 1'b1;
      end
   end

endmodule

### rtl/core/mtp_parse_core.sv
// parser state: group accumulation, octet store, error tracking, result build
module mtp_parse_core import mtp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           take,
   input  char_class_type cls,
   output result_type     result
);

   logic [GROUP_W-1:0] gv_ff, gv_in;
   logic               ovf_ff, ovf_in;
   logic               dot_ff, dot_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   status_type         err_ff, err_in;

   logic                         do_store;
   logic                         dot_eff;
   logic                         wr_hi;
   logic                         wr_lo;
   logic [CNT_W-1:0]             cnt_lo;
   logic [CNT_W-1:0]             pos_lo;
   status_type                   status_fin;
   logic [ADDR_W+OUT_ADDR_W-1:0] addr_pad;

   always_comb begin
      gv_in    = gv_ff;
      ovf_in   = ovf_ff;
      dot_in   = dot_ff;
      cnt_in   = cnt_ff;
      addr_in  = addr_ff;
      err_in   = err_ff;
      do_store = 1'b0;
      dot_eff  = dot_ff;
      wr_hi    = 1'b0;
      wr_lo    = 1'b0;
      cnt_lo   = cnt_ff + CNT_W'(1);
      pos_lo   = cnt_ff;

      if (take) begin
         if (cls.is_digit) begin
            ovf_in = ovf_ff | (gv_ff[GROUP_W-1:GROUP_W-4] != '0);
            gv_in  = {gv_ff[GROUP_W-5:0], cls.digit};
         end else if (cls.is_bad) begin
            if (err_ff == ST_OK) begin
               err_in = ST_BAD_CHAR;
            end
         end else begin
            do_store = 1'b1;
            if (cls.is_dot) begin
               dot_in  = 1'b1;
               dot_eff = 1'b1;
            end
         end
      end

      if (do_store && err_ff == ST_OK) begin
         gv_in  = '0;
         ovf_in = 1'b0;
         if (dot_eff) begin
            pos_lo = cnt_lo;
            if (ovf_ff) begin
               err_in = ST_TOO_LARGE;
            end else if (cnt_ff >= CNT_W'(ADDR_OCTETS)) begin
               err_in = ST_TOO_LONG;
            end else begin
               wr_hi = 1'b1;
               if (cnt_lo >= CNT_W'(ADDR_OCTETS)) begin
                  err_in = ST_TOO_LONG;
               end else begin
                  wr_lo  = 1'b1;
                  cnt_in = cnt_lo + CNT_W'(1);
               end
            end
         end else begin
            if (ovf_ff || gv_ff[GROUP_W-1:8] != '0) begin
               err_in = ST_TOO_LARGE;
            end else if (cnt_ff >= CNT_W'(ADDR_OCTETS)) begin
               err_in = ST_TOO_LONG;
            end else begin
               wr_lo  = 1'b1;
               cnt_in = cnt_lo;
            end
         end
      end

      for (int j = 0; j < ADDR_OCTETS; j++) begin
         if (wr_hi && cnt_ff == CNT_W'(j)) begin
            addr_in[8*(ADDR_OCTETS-1-j) +: 8] = gv_ff[15:8];
         end
         if (wr_lo && pos_lo == CNT_W'(j)) begin
            addr_in[8*(ADDR_OCTETS-1-j) +: 8] = gv_ff[7:0];
         end
      end

      // result as seen at a terminator
      if (err_in == ST_OK && cnt_in < CNT_W'(ADDR_OCTETS)) begin
         status_fin = ST_TOO_SHORT;
      end else begin
         status_fin = err_in;
      end
      addr_pad       = {{OUT_ADDR_W{1'b0}}, addr_in};
      result.status  = status_fin;
      result.address = (status_fin == ST_OK) ? addr_pad[OUT_ADDR_W-1:0] : '0;

      if (take && cls.is_term) begin
         gv_in   = '0;
         ovf_in  = 1'b0;
         dot_in  = 1'b0;
         cnt_in  = '0;
         addr_in = '0;
         err_in  = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gv_ff   <= '0;
         ovf_ff  <= 1'b0;
         dot_ff  <= 1'b0;
         cnt_ff  <= '0;
         addr_ff <= '0;
         err_ff  <= ST_OK;
      end else begin
         gv_ff   <= gv_in;
         ovf_ff  <= ovf_in;
         dot_ff  <= dot_in;
         cnt_ff  <= cnt_in;
         addr_ff <= addr_in;
         err_ff  <= err_in;
      end
   end

endmodule

### rtl/core/mac_address_text_parser.sv
// top level of the mac address text parser: input word register, parser, result register
//
// The req_ channel carries one character per word on req_ch; a zero character
// ends the address string. Hex digits of either case build a group; ':' and
// '-' close a group as one octet, and after a '.' every group closes as two
// octets. Each terminator yields one word on the rsp_ channel: rsp_address
// (first octet in the top byte, zero on error) and rsp_status (0 ok, 1 bad
// char, 2 group too large, 3 too short, 4 too long); other characters give
// no word. The parser then starts over for the next string.
// Throughput is one character per cycle unless req_stall holds the flow. A
// character waits in the input register until the parser takes it, and a
// terminator's result shows on rsp_valid in the cycle after it is taken.
// While a result waits under rsp_stall, non-terminator characters keep
// flowing; a terminator waits in the input register and req_stall rises
// until the result register frees up. Reset clears both valid flags and the
// parser state; no word is pending after reset.
module mac_address_text_parser import mtp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_ch,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [OUT_ADDR_W-1:0] rsp_address,
   output logic [2:0]            rsp_status
);

   logic                  a_vld_ff, a_vld_in;
   logic [7:0]            a_ch_ff, a_ch_in;
   logic                  r_vld_ff, r_vld_in;
   logic [OUT_ADDR_W-1:0] r_addr_ff, r_addr_in;
   status_type            r_status_ff, r_status_in;

   char_class_type cls;
   result_type     result;
   logic           out_free;
   logic           a_take;
   logic           req_take;

   mtp_char_decode u_decode (
      .ch  (a_ch_ff),
      .cls (cls)
   );

   mtp_parse_core u_core (
      .clock  (clock),
      .reset  (reset),
      .take   (a_take),
      .cls    (cls),
      .result (result)
   );

   assign out_free  = !r_vld_ff || !rsp_stall;
   assign a_take    = a_vld_ff && (!cls.is_term || out_free);
   assign req_stall = a_vld_ff && !a_take;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      a_vld_in    = a_vld_ff;
      a_ch_in     = a_ch_ff;
      r_vld_in    = r_vld_ff;
      r_addr_in   = r_addr_ff;
      r_status_in = r_status_ff;
      if (req_take) begin
         a_vld_in = 1'b1;
         a_ch_in  = req_ch;
      end else if (a_take) begin
         a_vld_in = 1'b0;
      end
      if (out_free) begin
         r_vld_in = a_take && cls.is_term;
         if (a_take && cls.is_term) begin
            r_addr_in   = result.address;
            r_status_in = result.status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         r_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         r_vld_ff <= r_vld_in;
      end
      a_ch_ff     <= a_ch_in;
      r_addr_ff   <= r_addr_in;
      r_status_ff <= r_status_in;
   end

   assign rsp_valid   = r_vld_ff;
   assign rsp_address = r_addr_ff;
   assign rsp_status  = r_status_ff;

endmodule

### rtl/core/mtp_checker.sv
// port-level checker for the mac address text parser and its bind
module mtp_checker import mtp_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [OUT_ADDR_W-1:0] rsp_address,
   input logic [2:0]            rsp_status
);

   // input only backs up behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_address) && $stable(rsp_status)))
      else $error("stalled result word changed");

   a_err_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_address == '0))
      else $error("error result with nonzero address");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_TOO_LONG))
      else $error("status code out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word pending after reset");

endmodule

bind mac_address_text_parser mtp_checker u_mtp_checker (.*);
